// ===== design/fsq_pkg.sv =====
// ----------------------------------------------------------------------------
// fsq_pkg
// shared constants, request and status codes and the cell control bundle
// for the fifo queue with search
// ----------------------------------------------------------------------------
`default_nettype none

package fsq_pkg;

	// queue geometry
	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SHOW = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SRCH = 2'd3;

	// result status
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// cell operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_HOLD = 3'd0;
	localparam logic [OP_W-1:0] OP_ENQ  = 3'd1;
	localparam logic [OP_W-1:0] OP_DEQ  = 3'd2;
	localparam logic [OP_W-1:0] OP_ROT  = 3'd3;
	localparam logic [OP_W-1:0] OP_CMP  = 3'd4;

	// broadcast to every cell of the row
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] key;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/fifo_queue_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// first-in first-out queue of signed 32-bit words with membership search,
// built as a row of slot cells that shift toward the head
// ----------------------------------------------------------------------------
// usage
//   input channel: kind, value with in_valid / in_stall; a word is taken at a
//   rising edge with in_valid high and in_stall low
//   output channel: value_out, found, status, last with out_valid / out_stall
//   enqueue and dequeue: result in the output register the cycle after the
//   request is taken; a new request may follow at once unless the receiver stalls
//   search: the cells register their compares, then the match bits of all
//   DEPTH cells are or-reduced into the result
//   show: one result per stored word, one per cycle while the receiver does not
//   stall, the row rotating by one slot per result so that it ends in its
//   original order; an empty show gives one result
//   the single output register frees the input side as soon as the result is
//   taken or in the same cycle it is taken; while the receiver stalls, the
//   pending result holds and no new request is taken
//   reset clears all valid bits, the fill count and the sequencer; stored
//   words are not cleared and are never read before being written
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_search_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [fsq_pkg::KIND_W-1:0]        kind,
	input  wire logic signed [fsq_pkg::DATA_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [fsq_pkg::DATA_W-1:0]      value_out,
	output logic                                   found,
	output logic [fsq_pkg::STAT_W-1:0]             status,
	output logic                                   last
);
	import fsq_pkg::*;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SHOW = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;

	localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
	localparam logic [DEPTH-1:0]  ROW_ONE  = DEPTH'(1);

	logic [1:0]       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [CNT_W-1:0] rem_q, rem_nxt;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] value_out_q;
	logic                     found_q;
	logic [STAT_W-1:0]        status_q;
	logic                     last_q;

	// next result word
	logic                     emit;
	logic signed [DATA_W-1:0] res_value;
	logic                     res_found;
	logic [STAT_W-1:0]        res_status;
	logic                     res_last;

	// row of cells
	cell_ctl_t                ctl;
	logic [DEPTH-1:0]         cell_valid;
	logic [DEPTH-1:0]         cell_match;
	logic signed [DATA_W-1:0] cell_data [DEPTH];

	logic out_free;
	logic take;
	logic acc;
	logic empty;
	logic full;

	// output register empties this cycle or already is empty
	assign out_free = !out_valid_q || !out_stall;
	assign take     = (state_q == ST_IDLE) && out_free;
	assign in_stall = !take;
	assign acc      = in_valid && take;

	// the row is packed toward slot 0, so its ends give empty and full
	assign empty = !cell_valid[0];
	assign full  = cell_valid[DEPTH-1];

	// sequencer and result selection
	always_comb begin
		state_nxt  = state_q;
		cnt_nxt    = cnt_q;
		rem_nxt    = rem_q;
		ctl.op     = OP_HOLD;
		ctl.key    = value;
		emit       = 1'b0;
		res_value  = '0;
		res_found  = 1'b0;
		res_status = STAT_OK;
		res_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (kind)
						KIND_ENQ: begin
							emit = 1'b1;
							if (full) begin
								// dropped, state unchanged
								res_status = STAT_FULL;
							end else begin
								ctl.op  = OP_ENQ;
								cnt_nxt = cnt_q + CNT_ONE;
							end
						end
						KIND_DEQ: begin
							emit = 1'b1;
							if (empty) begin
								res_value  = '1;
								res_status = STAT_EMPTY;
							end else begin
								res_value = cell_data[0];
								ctl.op    = OP_DEQ;
								cnt_nxt   = cnt_q - CNT_ONE;
							end
						end
						KIND_SHOW: begin
							emit = 1'b1;
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								// first word goes out now, the rest from the show state
								res_value = cell_data[0];
								res_last  = (cnt_q == CNT_ONE);
								ctl.op    = OP_ROT;
								rem_nxt   = cnt_q - CNT_ONE;
								if (cnt_q != CNT_ONE) begin
									state_nxt = ST_SHOW;
								end
							end
						end
						KIND_SRCH: begin
							ctl.op    = OP_CMP;
							state_nxt = ST_SRCH;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHOW: begin
				if (out_free) begin
					emit      = 1'b1;
					res_value = cell_data[0];
					res_last  = (rem_q == CNT_ONE);
					ctl.op    = OP_ROT;
					rem_nxt   = rem_q - CNT_ONE;
					if (rem_q == CNT_ONE) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_SRCH: begin
				if (out_free) begin
					emit      = 1'b1;
					res_found = |cell_match;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			rem_q   <= rem_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word, loaded only when the register is free
	always_ff @(posedge clk) begin
		if (emit) begin
			value_out_q <= res_value;
			found_q     <= res_found;
			status_q    <= res_status;
			last_q      <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign found     = found_q;
	assign status    = status_q;
	assign last      = last_q;

	// slot 0 is the head, each slot hears its neighbor toward the tail
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_v;
		logic                     next_v;
		logic signed [DATA_W-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_link
			assign next_v = cell_valid[i+1];
			assign next_d = cell_data[i+1];
		end

		fsq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_data  (next_d),
			.head_data  (cell_data[0]),
			.valid      (cell_valid[i]),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	// fill count agrees with the valid bits of the row
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(cnt_q))
		else $error("fill count differs from occupied slots");

	// occupied slots stay packed toward the head
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + ROW_ONE)) == '0)
		else $error("gap in the slot row");

	// a show in progress always has words left to send
	a_show: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW) |-> (!empty && rem_q != '0))
		else $error("show running on an empty queue");

	// a search result, with last set and status ok, follows once the output is free in the search state
	a_srch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH && out_free) |=> (out_valid_q && last_q && status_q == STAT_OK))
		else $error("search result missing");

endmodule

`default_nettype wire

// ===== design/fsq_cell.sv =====
// ----------------------------------------------------------------------------
// fsq_cell
// one slot of the queue row: holds a word and its valid bit, takes the
// neighbor's word on a shift and compares against the search key
// ----------------------------------------------------------------------------
`default_nettype none

module fsq_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire fsq_pkg::cell_ctl_t               ctl,
	input  wire logic                             prev_valid,
	input  wire logic                             next_valid,
	input  wire logic signed [fsq_pkg::DATA_W-1:0] next_data,
	input  wire logic signed [fsq_pkg::DATA_W-1:0] head_data,
	output logic                                  valid,
	output logic signed [fsq_pkg::DATA_W-1:0]      data,
	output logic                                  match
);
	import fsq_pkg::*;

	logic                     valid_q;
	logic                     match_q;
	logic signed [DATA_W-1:0] data_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_ENQ: begin
					if (!valid_q && prev_valid) begin
						valid_q <= 1'b1;
					end
				end
				OP_DEQ: begin
					valid_q <= next_valid;
				end
				OP_CMP: begin
					match_q <= valid_q && (data_q == ctl.key);
				end
				default: begin
				end
			endcase
		end
	end

	// stored word
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ENQ: begin
				if (!valid_q && prev_valid) begin
					data_q <= ctl.key;
				end
			end
			OP_DEQ: begin
				data_q <= next_data;
			end
			OP_ROT: begin
				// the newest slot wraps the head word around
				if (valid_q && !next_valid) begin
					data_q <= head_data;
				end else if (valid_q) begin
					data_q <= next_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ===== bench/tb_fifo_queue_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search_unit
// self-checking bench for the fifo queue with search: a queued driver feeds
// requests, a shadow queue predicts every result and a monitor compares the
// output words field by field, with random idle on input and stall on output channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fifo_queue_with_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fsq_pkg::*;

	// one request word on the input channel
	typedef struct {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] value;
	} request_t;

	// one result word on the output channel
	typedef struct {
		logic signed [DATA_W-1:0] value_out;
		logic                     found;
		logic [STAT_W-1:0]        status;
		logic                     last;
	} reply_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic [KIND_W-1:0]        kind      = KIND_ENQ;
	logic signed [DATA_W-1:0] value     = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] value_out;
	logic                     found;
	logic [STAT_W-1:0]        status;
	logic                     last;

	request_t                 request_q[$];   // words still to be sent
	reply_t                   reply_q[$];     // results still to arrive
	logic signed [DATA_W-1:0] queue_model[$]; // stored words, oldest first
	logic signed [DATA_W-1:0] sent_values[$]; // every value ever enqueued
	int unsigned              words_taken = 0;
	int unsigned              errors      = 0;
	logic                     gaps_on;

	fifo_queue_with_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.found     (found),
		.status    (status),
		.last      (last)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// a stretch of input words with no idle or stall on either side
	assign gaps_on = !(words_taken >= 90 && words_taken < 150);

	// push the results one accepted request must produce, update the shadow queue
	task automatic predict_replies(input logic [KIND_W-1:0] req_kind,
			input logic signed [DATA_W-1:0] req_value);
		reply_t r;
		logic   hit;
		int     i;
		r = '{value_out: '0, found: 1'b0, status: STAT_OK, last: 1'b1};
		case (req_kind)
			KIND_ENQ: begin
				// a full queue drops the word and keeps its contents
				if (queue_model.size() >= DEPTH)
					r.status = STAT_FULL;
				else
					queue_model.push_back(req_value);
				reply_q.push_back(r);
			end
			KIND_DEQ: begin
				if (queue_model.size() == 0) begin
					r.value_out = -1;
					r.status    = STAT_EMPTY;
				end else begin
					r.value_out = queue_model.pop_front();
				end
				reply_q.push_back(r);
			end
			KIND_SHOW: begin
				if (queue_model.size() == 0) begin
					r.status = STAT_EMPTY;
					reply_q.push_back(r);
				end else begin
					// one word per entry, last only on the newest
					for (i = 0; i < queue_model.size(); i++) begin
						r.value_out = queue_model[i];
						r.last      = (i == queue_model.size() - 1);
						reply_q.push_back(r);
					end
				end
			end
			default: begin
				hit = 1'b0;
				foreach (queue_model[j])
					if (queue_model[j] == req_value)
						hit = 1'b1;
				r.found = hit;
				reply_q.push_back(r);
			end
		endcase
	endtask

	task automatic add_request(input logic [KIND_W-1:0] req_kind,
			input logic signed [DATA_W-1:0] req_value);
		request_q.push_back('{kind: req_kind, value: req_value});
		if (req_kind == KIND_ENQ)
			sent_values.push_back(req_value);
	endtask

	// half full-range values, a quarter extremes and a quarter from a narrow set for duplicates
	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(3))
			0: return $urandom_range(7);
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return -1;
					default: return 0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// search keys: half of them taken from earlier enqueues so hits happen
	function automatic logic signed [DATA_W-1:0] recall_value();
		if (sent_values.size() != 0 && $urandom_range(1) == 1)
			return sent_values[$urandom_range(sent_values.size() - 1)];
		return random_value();
	endfunction

	task automatic build_directed();
		// empty queue: dequeue, show and search
		add_request(KIND_DEQ, $urandom());
		add_request(KIND_SHOW, $urandom());
		add_request(KIND_SRCH, -1);
		// extremes of the value field
		add_request(KIND_ENQ, 32'sh7FFF_FFFF);
		add_request(KIND_ENQ, 32'sh8000_0000);
		add_request(KIND_ENQ, 0);
		add_request(KIND_ENQ, -1);
		// hits at both ends and the middle, then a miss
		add_request(KIND_SRCH, -1);
		add_request(KIND_SRCH, 32'sh7FFF_FFFF);
		add_request(KIND_SRCH, 32'sh8000_0000);
		add_request(KIND_SRCH, 1);
		add_request(KIND_SHOW, $urandom());
		add_request(KIND_DEQ, $urandom());
		add_request(KIND_DEQ, $urandom());
		add_request(KIND_SHOW, $urandom());
		add_request(KIND_SRCH, 32'sh7FFF_FFFF);
		// drain to empty and dequeue once more
		add_request(KIND_DEQ, $urandom());
		add_request(KIND_DEQ, $urandom());
		add_request(KIND_DEQ, $urandom());
		add_request(KIND_SHOW, $urandom());
	endtask

	task automatic build_random(input int unsigned budget);
		int unsigned made;
		int unsigned seg_len;
		int unsigned enq_pct;
		int unsigned deq_pct;
		int unsigned pick;
		int unsigned i;
		// fill past the top once: dropped enqueues, a full show, searches
		for (i = 0; i < DEPTH + 4; i++)
			add_request(KIND_ENQ, random_value());
		add_request(KIND_SHOW, $urandom());
		add_request(KIND_SRCH, recall_value());
		add_request(KIND_SRCH, $urandom());
		made = DEPTH + 7;
		// segments that push the fill level up, down or keep it wandering
		while (made < budget) begin
			seg_len = $urandom_range(30, 10);
			case ($urandom_range(2))
				0: begin enq_pct = 60; deq_pct = 20; end
				1: begin enq_pct = 15; deq_pct = 65; end
				default: begin enq_pct = 35; deq_pct = 35; end
			endcase
			for (i = 0; i < seg_len; i++) begin
				pick = $urandom_range(99);
				if (pick < enq_pct)
					add_request(KIND_ENQ, random_value());
				else if (pick < enq_pct + deq_pct)
					add_request(KIND_DEQ, $urandom());
				else if (pick < enq_pct + deq_pct + (100 - enq_pct - deq_pct) / 3)
					add_request(KIND_SHOW, $urandom());
				else
					add_request(KIND_SRCH, recall_value());
				made++;
			end
		end
	endtask

	// driver: prediction at acceptance, next word or idle after it
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_replies(kind, value);
				void'(request_q.pop_front());
				words_taken++;
			end
			// a stalled word holds; otherwise present the next one or idle
			if (!in_valid || !in_stall) begin
				if (request_q.size() != 0 && !(gaps_on && $urandom_range(99) < 10)) begin
					in_valid <= 1'b1;
					kind     <= request_q[0].kind;
					value    <= request_q[0].value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: receiver stall and the field-by-field compare
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			out_stall <= gaps_on && ($urandom_range(99) < 10);
			if (out_valid && !out_stall) begin
				if (reply_q.size() == 0) begin
					$display("%0t: result word expected none actual value_out %h status %0d",
						$realtime, value_out, status);
					errors++;
				end else begin
					want = reply_q.pop_front();
					if (value_out !== want.value_out) begin
						$display("%0t: value_out expected %h actual %h",
							$realtime, want.value_out, value_out);
						errors++;
					end
					if (found !== want.found) begin
						$display("%0t: found expected %b actual %b",
							$realtime, want.found, found);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, want.status, status);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %b actual %b",
							$realtime, want.last, last);
						errors++;
					end
				end
			end
		end
	end

	// stimulus, reset, drain and verdict
	initial begin
		build_directed();
		build_random(170);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// wait until every word is sent and every result has come back
		while (request_q.size() != 0 || in_valid || reply_q.size() != 0)
			@(negedge clk);
		// keep running to catch any stray result
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("fifo_queue_with_search_unit verification clean");
		else
			$display("fifo_queue_with_search_unit verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("fifo_queue_with_search_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/fsq_pkg.sv
design/fsq_cell.sv
design/fifo_queue_with_search_unit.sv
bench/tb_fifo_queue_with_search_unit.sv
